// ===== design/assert_macros.svh =====
// Assertion macros used by the checker module of this block.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define TOFGA_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("tofga checker: same-cycle implication failed");

// Next-cycle implication, off while reset is asserted
`define TOFGA_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("tofga checker: next-cycle implication failed");

// Next-cycle implication that also holds through reset
`define TOFGA_ASSERT_NXT_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("tofga checker: next-cycle implication failed in reset");

`endif

// ===== design/tofga_pkg.sv =====
// Shared constants and types of the time-of-flight glitch filter.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package tofga_pkg;

  // Q16.16 time width and signed up-minus-down difference width
  localparam int DATA_W = 32;
  localparam int DIFF_W = DATA_W + 1;

  // Default ring depth and reset value of the jump limit (300.0 in Q16.16)
  localparam int               RING_DEPTH_DEF = 16;
  localparam logic [DATA_W-1:0] JUMP_LIMIT_RST = 32'd19660800;

  // Configuration port address width (one 32-bit word)
  localparam int CFG_ADDR_W = 2;

  // Status and result from the serial divider
  typedef struct packed {
    logic              done;
    logic              neg;
    logic [DIFF_W-1:0] mag;
  } div_res_t;

endpackage

`default_nettype wire

// ===== design/tofga_if.sv =====
// Valid/ready channel interfaces for the measurement input and the result output.
// Depends on tofga_pkg for field widths.
`default_nettype none

interface tofga_in_if import tofga_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] tof_up;
  logic [DATA_W-1:0] tof_down;
  logic              timed_out;

  modport source (output valid, output tof_up, output tof_down, output timed_out,
                  input ready);
  modport sink   (input valid, input tof_up, input tof_down, input timed_out,
                  output ready);
endinterface

interface tofga_out_if import tofga_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [DATA_W-1:0]        kept_up;
  logic [DATA_W-1:0]        kept_down;
  logic                     replaced;
  logic                     timeout_error;
  logic signed [DIFF_W-1:0] mean_difference;

  modport source (output valid, output kept_up, output kept_down, output replaced,
                  output timeout_error, output mean_difference, input ready);
  modport sink   (input valid, input kept_up, input kept_down, input replaced,
                  input timeout_error, input mean_difference, output ready);
endinterface

`default_nettype wire

// ===== design/tof_glitch_filter_moving_average.sv =====
// Time-of-flight outlier-hold filter with a moving average of up-down differences.
// Depends on tofga_pkg, tofga_if, tofga_ram and tofga_div.
// Usage:
//   in_chan carries one measurement beat: tof_up, tof_down (unsigned Q16.16)
//   and timed_out. out_chan carries one result beat per input beat: the kept
//   pair, replaced, timeout_error and the signed Q16.16 mean difference.
//   jump_limit is read over APB at byte address 0 and set by any APB write; the
//   user must write it only while idle, which the block does not enforce.
// Sequencing:
//   A beat passes the steps DIFF, MAG, CMP, DEC and DGO, then the serial
//   divider, one quotient bit a cycle, before its result loads for out_chan;
//   one beat is in work at a time. The ring RAM is read at acceptance and
//   written at the decision step.
// Reset:
//   Synchronous, active low. Clears the previous pair, sum, fill count and
//   write slot, and sets jump_limit to 300.0. Ring contents are not cleared:
//   an entry is read only once the ring is full. No clearing pass is needed.
// Stall:
//   A finished result waits in the output register; the next beat may be
//   accepted meanwhile, and its own result waits until that register frees.
`default_nettype none

module tof_glitch_filter_moving_average import tofga_pkg::*; #(
  parameter int  RING_DEPTH = RING_DEPTH_DEF,
  localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
  localparam int CNT_W      = $clog2(RING_DEPTH + 1),
  localparam int SUM_W      = DIFF_W + $clog2(RING_DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0]     pwdata,
  output logic      [DATA_W-1:0]     prdata,
  output logic                       pready,
  tofga_in_if.sink                   in_chan,
  tofga_out_if.source                out_chan
);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIFF = 3'd1;
  localparam logic [2:0] S_MAG  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_DEC  = 3'd4;
  localparam logic [2:0] S_DGO  = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;

  logic [2:0]               state_r, state_nxt;
  logic [DATA_W-1:0]        jump_limit_r;
  logic                     cfg_wr;

  // Latched beat and working values
  logic [DATA_W-1:0]        up_r, down_r;
  logic                     tmo_r;
  logic signed [DIFF_W-1:0] d_new_r, old_r;
  logic [DATA_W-1:0]        nd_r, jump_r;
  logic signed [SUM_W-1:0]  sub_r;

  // Block state
  logic [DATA_W-1:0]        prev_up_r, prev_down_r, pd_r;
  logic signed [DIFF_W-1:0] prev_diff_r;
  logic                     rep_r;
  logic [SLOT_W-1:0]        slot_r;
  logic [CNT_W-1:0]         fill_r;
  logic signed [SUM_W-1:0]  sum_r;

  // Output register
  logic                     out_v_r, out_v_nxt;
  logic [DATA_W-1:0]        out_up_r, out_down_r;
  logic                     out_rep_r, out_tmo_r;
  logic signed [DIFF_W-1:0] out_mean_r;

  logic                     in_acc, out_load, full, rep, dec;
  logic signed [DIFF_W-1:0] diff, ram_rdata, d_neg;
  div_res_t                 div_res;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign full     = (fill_r == CNT_W'(RING_DEPTH));
  assign dec      = (state_r == S_DEC);
  assign out_load = (state_r == S_DIV) && div_res.done && (!out_v_r || out_chan.ready);

  // APB register: read at byte address 0, others read as zero; writes ignore paddr
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr == '0) ? jump_limit_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jump_limit_r <= JUMP_LIMIT_RST;
    end else if (cfg_wr) begin
      jump_limit_r <= pwdata;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_MAG;
      S_MAG:  state_nxt = S_CMP;
      S_CMP:  state_nxt = S_DEC;
      S_DEC:  state_nxt = S_DGO;
      S_DGO:  state_nxt = S_DIV;
      S_DIV:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_chan.ready = (state_r == S_IDLE);

  // Ring RAM: read the slot to be overwritten at acceptance, write at decision
  tofga_ram #(
    .WIDTH(DIFF_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (dec),
    .waddr(slot_r),
    .wdata(diff),
    .re   (in_acc),
    .raddr(slot_r),
    .rdata(ram_rdata)
  );

  // Decision: reject a jump larger than the limit, timeout pushes zero
  assign rep   = !tmo_r && (jump_r > jump_limit_r);
  assign diff  = tmo_r ? '0 : (rep ? prev_diff_r : d_new_r);
  assign d_neg = -d_new_r;

  // Datapath pipeline over the sequencer steps
  always_ff @(posedge clk) begin
    if (in_acc) begin
      up_r   <= in_chan.tof_up;
      down_r <= in_chan.tof_down;
      tmo_r  <= in_chan.timed_out;
    end
    if (state_r == S_DIFF) begin
      d_new_r <= $signed({1'b0, up_r}) - $signed({1'b0, down_r});
      old_r   <= full ? ram_rdata : '0;
    end
    if (state_r == S_MAG) begin
      nd_r  <= d_new_r[DIFF_W-1] ? d_neg[DATA_W-1:0] : d_new_r[DATA_W-1:0];
      sub_r <= sum_r - SUM_W'(old_r);
    end
    if (state_r == S_CMP) begin
      jump_r <= (nd_r >= pd_r) ? (nd_r - pd_r) : (pd_r - nd_r);
    end
    if (dec) begin
      rep_r <= rep;
    end
  end

  // Filter and ring state, updated at the decision step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_up_r   <= '0;
      prev_down_r <= '0;
      prev_diff_r <= '0;
      pd_r        <= '0;
      slot_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
    end else if (dec) begin
      if (tmo_r) begin
        prev_up_r   <= '0;
        prev_down_r <= '0;
        prev_diff_r <= '0;
        pd_r        <= '0;
      end else if (!rep) begin
        prev_up_r   <= up_r;
        prev_down_r <= down_r;
        prev_diff_r <= d_new_r;
        pd_r        <= nd_r;
      end
      sum_r  <= sub_r + SUM_W'(diff);
      slot_r <= (slot_r == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_r + 1'b1;
      if (!full) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  // Mean = running sum / entries held
  tofga_div #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (state_r == S_DGO),
    .dividend(sum_r),
    .divisor (fill_r),
    .res     (div_res)
  );

  // Output register: load when free or being drained, drop on the taken beat
  always_comb begin
    out_v_nxt = out_v_r;
    if (out_load) begin
      out_v_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_up_r   <= prev_up_r;
      out_down_r <= prev_down_r;
      out_rep_r  <= rep_r;
      out_tmo_r  <= tmo_r;
      out_mean_r <= div_res.neg ? $signed(-div_res.mag) : $signed(div_res.mag);
    end
  end

  assign out_chan.valid           = out_v_r;
  assign out_chan.kept_up         = out_up_r;
  assign out_chan.kept_down       = out_down_r;
  assign out_chan.replaced        = out_rep_r;
  assign out_chan.timeout_error   = out_tmo_r;
  assign out_chan.mean_difference = out_mean_r;

endmodule

`default_nettype wire

// ===== design/tofga_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tofga_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/tofga_div.sv =====
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating.
// Depends on tofga_pkg for the result struct.
`default_nettype none

module tofga_div import tofga_pkg::*; #(
  parameter int  SUM_W  = 37,
  parameter int  CNT_W  = 5,
  localparam int STEP_W = $clog2(SUM_W + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [SUM_W-1:0] dividend,
  input  wire logic        [CNT_W-1:0] divisor,
  output div_res_t                     res
);

  logic [SUM_W-1:0]  quo_r,  quo_nxt;
  logic [CNT_W-1:0]  rem_r,  rem_nxt;
  logic [CNT_W-1:0]  dvs_r,  dvs_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              neg_r,  neg_nxt;
  logic [CNT_W:0]    shifted;
  logic              ge;

  // One restoring step on the magnitude
  assign shifted = {rem_r, quo_r[SUM_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    neg_nxt  = neg_r;
    if (start) begin
      // load magnitude and sign, clear remainder
      quo_nxt  = dividend[SUM_W-1] ? (-dividend) : dividend;
      neg_nxt  = dividend[SUM_W-1];
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      step_nxt = STEP_W'(SUM_W);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract where it fits
      rem_nxt  = ge ? CNT_W'(shifted - {1'b0, dvs_r}) : shifted[CNT_W-1:0];
      quo_nxt  = {quo_r[SUM_W-2:0], ge};
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  // Mean magnitude never exceeds 2^32-1, so the low bits carry it
  assign res.done = done_r;
  assign res.neg  = neg_r;
  assign res.mag  = quo_r[DIFF_W-1:0];

endmodule

`default_nettype wire

// ===== design/tofga_checker.sv =====
// Port-level checker for the glitch filter, bound to the top level.
// Depends on tofga_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tofga_checker import tofga_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic [DATA_W-1:0]        out_kept_up,
  input wire logic [DATA_W-1:0]        out_kept_down,
  input wire logic                     out_replaced,
  input wire logic                     out_timeout_error,
  input wire logic signed [DIFF_W-1:0] out_mean_difference
);

  // Reset empties the output register
  `TOFGA_ASSERT_NXT_ALWAYS(a_reset_clears_out, clk, !rst_n, !out_valid)

  // One beat in work at a time: input closes right after a beat is taken
  `TOFGA_ASSERT_NXT(a_one_in_work, clk, rst_n, in_valid && in_ready, !in_ready)

  // A timeout result carries a zero pair and is never a replacement
  `TOFGA_ASSERT_IMP(a_timeout_zero_pair, clk, rst_n, out_valid && out_timeout_error, out_kept_up == '0 && out_kept_down == '0 && !out_replaced)

  // Hold a stalled result beat
  `TOFGA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_mean_difference) && $stable(out_kept_up))

endmodule

bind tof_glitch_filter_moving_average tofga_checker u_tofga_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_chan.valid),
  .in_ready           (in_chan.ready),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .out_kept_up        (out_chan.kept_up),
  .out_kept_down      (out_chan.kept_down),
  .out_replaced       (out_chan.replaced),
  .out_timeout_error  (out_chan.timeout_error),
  .out_mean_difference(out_chan.mean_difference)
);

`default_nettype wire
